FILE: src/click_hold_letter_entry_macros.svh
// ----------------------------------------------------------------------------
// click_hold_letter_entry_macros.svh
// Assertion macros shared by the letter entry block.
// ----------------------------------------------------------------------------
`ifndef CLICK_HOLD_LETTER_ENTRY_MACROS_SVH
`define CLICK_HOLD_LETTER_ENTRY_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CHLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/chle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chle_pkg
// Types, codes and the letter table of the click and hold letter entry block.
// ----------------------------------------------------------------------------
package chle_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 4'd1;

  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] HOLD_RST     = 16'd1000;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_NEXT    = 2'd1;
  localparam logic [1:0] EV_ENTER   = 2'd2;
  localparam logic [1:0] EV_IGNORED = 2'd3;

  localparam logic [2:0] GROUP_NONE  = 3'd0;
  localparam logic [2:0] CURSOR_HIDE = 3'd7;
  localparam logic [2:0] CURSOR_LAST = 3'd6;
  localparam logic [6:0] CHAR_SPACE  = 7'h20;

  typedef struct packed {
    logic       button_level;
    logic [3:0] group_lines;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] shown_letter;
    logic       letter_shown;
    logic [6:0] entered_char;
    logic [5:0] text_length;
    logic       text_full;
  } out_item_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [31:0] now;
    logic        level;
    logic [2:0]  sel;
  } tick_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // group is 1..4, cursor 0..6
  function automatic logic [6:0] letter_of(input logic [2:0] grp, input logic [2:0] cur);
    logic [6:0] base;
    logic [6:0] res;
    unique case (grp)
      3'd1:    base = 7'h40; // '@' so that '@'+1 is 'A'
      3'd2:    base = 7'h47; // 'G'
      3'd3:    base = 7'h4E; // 'N'
      default: base = 7'h55; // 'U'
    endcase
    if (grp == 3'd1) begin
      res = (cur == 3'd0) ? CHAR_SPACE : base + {4'd0, cur};
    end else if (grp == 3'd4 && cur == CURSOR_LAST) begin
      res = CHAR_SPACE;
    end else begin
      res = base + {4'd0, cur};
    end
    return res;
  endfunction

endpackage

FILE: src/chle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chle_queue
// Small first-in first-out buffer of register entries.
// ----------------------------------------------------------------------------
module chle_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: src/chle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chle_front
// Accepts ticks, stamps each with its time and decodes the group lines.
// ----------------------------------------------------------------------------
module chle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  chle_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_wr,
  output chle_pkg::tick_t   q_tick
);

  logic [31:0] now_r, now_nxt;
  logic [2:0]  sel;

  assign q_wr = push && !q_full;

  // lowest low line wins
  always_comb begin
    priority if (!in_item.group_lines[0]) begin
      sel = 3'd1;
    end else if (!in_item.group_lines[1]) begin
      sel = 3'd2;
    end else if (!in_item.group_lines[2]) begin
      sel = 3'd3;
    end else if (!in_item.group_lines[3]) begin
      sel = 3'd4;
    end else begin
      sel = chle_pkg::GROUP_NONE;
    end
  end

  always_comb begin
    q_tick.now   = now_r;
    q_tick.level = in_item.button_level;
    q_tick.sel   = sel;
    now_nxt      = q_wr ? now_r + 32'd1 : now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else begin
      now_r <= now_nxt;
    end
  end

endmodule

FILE: src/chle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chle_back
// Runs the press, release and hold rules on one tick a cycle, while a tick is
// waiting and the result queue has room, and builds the result beat.
// ----------------------------------------------------------------------------
module chle_back #(
  parameter int TEXT_LIMIT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  chle_pkg::cfg_wr_t  cfg_wr,
  input  logic               tick_valid,
  input  chle_pkg::tick_t    tick,
  output logic               tick_pop,
  input  logic               res_full,
  output logic               res_push,
  output chle_pkg::out_item_t res_item
);

  localparam logic [5:0] LIMIT = 6'(TEXT_LIMIT);

  logic [15:0] debounce_r, hold_r;
  logic        last_r, last_nxt;
  logic [31:0] press_r, press_nxt;
  logic [31:0] rel_r, rel_nxt;
  logic        skip_r, skip_nxt;
  logic [2:0]  group_r, group_nxt;
  logic [2:0]  cursor_r, cursor_nxt;
  logic [5:0]  count_r, count_nxt;

  logic        fire;
  logic [31:0] since_rel, since_press;
  logic        press_ok, rel_ok, hold_ok, shown_mid, shown_end;
  logic [1:0]  kind;
  logic [6:0]  entered;

  assign fire     = tick_valid && !res_full;
  assign tick_pop = fire;
  assign res_push = fire;

  assign since_rel   = tick.now - rel_r;
  assign since_press = tick.now - press_r;

  always_comb begin
    group_nxt  = group_r;
    cursor_nxt = cursor_r;
    press_nxt  = press_r;
    rel_nxt    = rel_r;
    skip_nxt   = skip_r;
    count_nxt  = count_r;
    kind       = chle_pkg::EV_NONE;
    entered    = '0;

    // a new group hides the cursor
    if (tick.sel != chle_pkg::GROUP_NONE && tick.sel != group_r) begin
      group_nxt  = tick.sel;
      cursor_nxt = chle_pkg::CURSOR_HIDE;
    end

    press_ok = !tick.level && last_r && (since_rel > {16'd0, debounce_r});
    rel_ok   = tick.level && !last_r && (since_press > {16'd0, debounce_r});
    // a press counted now restarts the timer, so no hold on the same tick
    hold_ok  = !tick.level && !press_ok && (since_press > {16'd0, hold_r});

    if (press_ok) begin
      press_nxt = tick.now;
    end

    if (rel_ok) begin
      if (!skip_r) begin
        if (group_nxt != chle_pkg::GROUP_NONE) begin
          cursor_nxt = (cursor_nxt >= chle_pkg::CURSOR_LAST) ? 3'd0 : cursor_nxt + 3'd1;
          kind       = chle_pkg::EV_NEXT;
        end
      end else begin
        skip_nxt = 1'b0;
      end
      rel_nxt = tick.now;
    end

    shown_mid = (group_nxt != chle_pkg::GROUP_NONE) && (cursor_nxt <= chle_pkg::CURSOR_LAST);

    if (hold_ok) begin
      if (shown_mid) begin
        entered    = chle_pkg::letter_of(group_nxt, cursor_nxt);
        count_nxt  = (count_r < LIMIT) ? count_r + 6'd1 : count_r;
        cursor_nxt = chle_pkg::CURSOR_HIDE;
        kind       = chle_pkg::EV_ENTER;
      end else begin
        kind = chle_pkg::EV_IGNORED;
      end
      skip_nxt  = 1'b1;
      press_nxt = tick.now;
    end

    last_nxt  = tick.level;
    shown_end = (group_nxt != chle_pkg::GROUP_NONE) && (cursor_nxt <= chle_pkg::CURSOR_LAST);

    res_item.event_kind   = kind;
    res_item.shown_letter = shown_end ? chle_pkg::letter_of(group_nxt, cursor_nxt)
                                      : chle_pkg::CHAR_SPACE;
    res_item.letter_shown = shown_end;
    res_item.entered_char = entered;
    res_item.text_length  = count_nxt;
    res_item.text_full    = (count_nxt >= LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= chle_pkg::DEBOUNCE_RST;
      hold_r     <= chle_pkg::HOLD_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        chle_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wr.data;
        chle_pkg::CFG_HOLD:     hold_r     <= cfg_wr.data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b1;
      press_r  <= '0;
      rel_r    <= '0;
      skip_r   <= 1'b0;
      group_r  <= chle_pkg::GROUP_NONE;
      cursor_r <= chle_pkg::CURSOR_HIDE;
      count_r  <= '0;
    end else if (fire) begin
      last_r   <= last_nxt;
      press_r  <= press_nxt;
      rel_r    <= rel_nxt;
      skip_r   <= skip_nxt;
      group_r  <= group_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/click_hold_letter_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// click_hold_letter_entry
// Click and hold letter entry: one millisecond tick in, one result beat out.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick; every tick yields exactly one
// result beat. The block takes one tick per clock cycle while its queues
// have room: the front stamps and decodes a tick, a two-entry queue passes it
// to the back, which updates all timing and cursor state, and a two-entry
// result queue holds finished beats; a tick and its result are registered
// in turn in the two queues. Configuration writes complete in the cycle they
// are offered (cfg_ready is always high); write only while the block is idle.
// ----------------------------------------------------------------------------
module click_hold_letter_entry #(
  parameter int TEXT_LIMIT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  chle_pkg::in_item_t                in_item,
  output logic                              full,
  output logic                              empty,
  input  logic                              pop,
  output chle_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chle_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "click_hold_letter_entry_macros.svh"

  localparam int TICK_W = $bits(chle_pkg::tick_t);
  localparam int RES_W  = $bits(chle_pkg::out_item_t);

  chle_pkg::tick_t     fr_tick, bk_tick;
  chle_pkg::out_item_t res_item;
  chle_pkg::cfg_wr_t   cfg_wr;
  logic                fr_wr, tq_full, tq_empty, tq_pop;
  logic                res_full, res_push;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;
  assign full         = tq_full;

  chle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .q_full  (tq_full),
    .q_wr    (fr_wr),
    .q_tick  (fr_tick)
  );

  chle_queue #(.WIDTH(TICK_W), .DEPTH(2)) u_tick_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_wr),
    .wr_data (fr_tick),
    .full    (tq_full),
    .rd_en   (tq_pop),
    .rd_data (bk_tick),
    .empty   (tq_empty)
  );

  chle_back #(.TEXT_LIMIT(TEXT_LIMIT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .tick_valid (!tq_empty),
    .tick       (bk_tick),
    .tick_pop   (tq_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  chle_queue #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

  `CHLE_ASSERT_NOW(a_full_flag, !empty, out_item.text_full == (out_item.text_length == 6'(TEXT_LIMIT)), "text_full disagrees with text_length")
  `CHLE_ASSERT_NOW(a_hidden_space, !empty && !out_item.letter_shown, out_item.shown_letter == chle_pkg::CHAR_SPACE, "hidden cursor shows a letter")
  `CHLE_ASSERT_NOW(a_enter_hides, res_push && res_item.event_kind == chle_pkg::EV_ENTER, !res_item.letter_shown, "cursor still shown after enter")
  `CHLE_ASSERT_NOW(a_back_fire, res_push, tq_pop && !tq_empty && !res_full, "back fired without tick or room")
  `CHLE_ASSERT_NEXT(a_tick_stamp, fr_wr, u_front.now_r == $past(fr_tick.now) + 32'd1, "tick time did not advance")

endmodule
